[src/u8u32_pkg.sv]
`default_nettype none

package u8u32_pkg;

  // One incoming byte of a string.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_word_t;

  // One decoded code point with its running counts.
  typedef struct packed {
    logic [31:0] code_point;
    logic        needs_pair;
    logic [15:0] point_count;
    logic [15:0] unit_count;
    logic        string_end;
  } cp_word_t;

  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;
  localparam logic [31:0] PAIR_LIMIT = 32'h0000_FFFF;

  // Value bits of a starting byte: leading-ones prefix and its zero masked off.
  function automatic logic [31:0] start_value(input logic [7:0] b);
    logic [7:0] v;
    if (!b[7]) begin
      v = b & 8'h7F;
    end else if (!b[6]) begin
      v = b & 8'h3F;
    end else if (!b[5]) begin
      v = b & 8'h1F;
    end else if (!b[4]) begin
      v = b & 8'h0F;
    end else if (!b[3]) begin
      v = b & 8'h07;
    end else if (!b[2]) begin
      v = b & 8'h03;
    end else if (!b[1]) begin
      v = b & 8'h01;
    end else begin
      v = 8'h00;
    end
    return {24'h000000, v};
  endfunction

endpackage

`default_nettype wire

[src/utf8_to_utf32_stream_decoder.sv]
// Lenient UTF-8 to UTF-32 stream decoder.
// Byte channel (byte_valid/byte_ready/byte_data): one UTF-8 byte per word,
// with final_byte set on the last byte of each string.
// Code point channel (cp_valid/cp_ready/cp_data): one decoded code point per
// word, with its surrogate-pair flag, the running code point and UTF-16 unit
// counts (saturating at 2^COUNT_WIDTH-1, low 16 bits shown) and string_end.
// A code point leaves when the next starting byte arrives or at the final
// byte; a final starting byte that follows a pending code point gives two
// words. Words caused by a byte are registered in the result queue first.
// Throughput: one byte per cycle, limited only by the three-entry result
// queue; byte_ready is high while at least two entries are free, so a byte
// giving two words needs the receiver to drain one extra word over time.
// A stalled receiver fills the queue and byte_ready drops; nothing is lost.
// Reset (rst, synchronous) empties the queue and clears the accumulator,
// the pending flag and both counts.
`default_nettype none

module utf8_to_utf32_stream_decoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        byte_valid,
  output logic                       byte_ready,
  input  wire u8u32_pkg::byte_word_t byte_data,
  output logic                       cp_valid,
  input  wire                        cp_ready,
  output u8u32_pkg::cp_word_t        cp_data
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Decoder state
  logic [31:0]            acc;
  logic                   pending;
  logic [COUNT_WIDTH-1:0] points;
  logic [COUNT_WIDTH-1:0] units;

  // Result queue: three entries, ring pointers over 0..2
  u8u32_pkg::cp_word_t queue [3];
  logic [1:0] wptr, rptr, fill;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                    input logic [1:0] n);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {{(COUNT_WIDTH-1){1'b0}}, n};
    return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  logic                   take, pop;
  logic                   is_cont, extend, emit0, emit1;
  logic [31:0]            acc_new;
  logic                   pair0, pair1;
  logic [COUNT_WIDTH-1:0] points_a, units_a, points_b, units_b;
  u8u32_pkg::cp_word_t    res0, res1;
  logic [1:0]             n_push;

  assign take       = byte_valid && byte_ready;
  assign pop        = cp_valid && cp_ready;
  assign byte_ready = (fill <= 2'd1);
  assign cp_valid   = (fill != 2'd0);
  assign cp_data    = queue[rptr];

  always_comb begin
    is_cont = (byte_data.data_byte & u8u32_pkg::CONT_MASK) == u8u32_pkg::CONT_TAG;
    extend  = pending && is_cont;
    emit0   = pending && !is_cont;   // starting byte flushes the pending point
    emit1   = byte_data.final_byte;
    acc_new = extend ? {acc[25:0], byte_data.data_byte[5:0]}
                     : u8u32_pkg::start_value(byte_data.data_byte);

    pair0    = acc > u8u32_pkg::PAIR_LIMIT;
    points_a = emit0 ? sat_add(points, 2'd1) : points;
    units_a  = emit0 ? sat_add(units, pair0 ? 2'd2 : 2'd1) : units;

    pair1    = acc_new > u8u32_pkg::PAIR_LIMIT;
    points_b = sat_add(points_a, 2'd1);
    units_b  = sat_add(units_a, pair1 ? 2'd2 : 2'd1);

    res0.code_point  = acc;
    res0.needs_pair  = pair0;
    res0.point_count = 16'(points_a);
    res0.unit_count  = 16'(units_a);
    res0.string_end  = 1'b0;

    res1.code_point  = acc_new;
    res1.needs_pair  = pair1;
    res1.point_count = 16'(points_b);
    res1.unit_count  = 16'(units_b);
    res1.string_end  = 1'b1;

    n_push = take ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pending <= 1'b0;
      points  <= '0;
      units   <= '0;
    end else if (take) begin
      if (emit1) begin
        acc     <= '0;
        pending <= 1'b0;
        points  <= '0;
        units   <= '0;
      end else begin
        acc     <= acc_new;
        pending <= 1'b1;
        points  <= points_a;
        units   <= units_a;
      end
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      if (emit0) begin
        queue[wptr] <= res0;
        if (emit1) begin
          queue[ptr_inc(wptr)] <= res1;
        end
      end else if (emit1) begin
        queue[wptr] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 2'd0;
      rptr <= 2'd0;
      fill <= 2'd0;
    end else begin
      case (n_push)
        2'd1:    wptr <= ptr_inc(wptr);
        2'd2:    wptr <= ptr_inc(ptr_inc(wptr));
        default: wptr <= wptr;
      endcase
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      fill <= fill + n_push - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire
